### rtl/core/hat_pkg.sv
// shared types and constants of the heap allocation tracker
package hat_pkg;

    localparam int TABLE_SLOTS_DEF  = 16;
    localparam int ADDRESS_BITS_DEF = 16;
    localparam int FIELD_ADDR_BITS  = 16;
    localparam int SLOT_FIELD_BITS  = 4;

    typedef enum logic {
        EV_ALLOC   = 1'b0,
        EV_RELEASE = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_ALLOC     = 3'd0,
        ST_FULL      = 3'd1,
        ST_FREED     = 3'd2,
        ST_UNTRACKED = 3'd3,
        ST_NULL      = 3'd4
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] address;
        logic [15:0] block_size;
    } in_t;

    typedef struct packed {
        status_t                    status;
        logic [SLOT_FIELD_BITS-1:0] slot;
        logic [15:0]                released_size;
        logic [15:0]                bytes_in_use;
        logic [15:0]                total_allocated;
        logic [15:0]                total_freed;
        logic [15:0]                alloc_events;
        logic [15:0]                free_events;
    } out_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_null;
        logic hit;
        logic scan_end;
    } dp_stat_t;

endpackage

### rtl/core/heap_allocation_tracker_core.sv
// Heap allocation tracker: keeps a table of TABLE_SLOTS live heap blocks (address and size)
// and running byte and event totals that wrap at 16 bits. Each allocation or release event
// on the s_ channel yields one result on the m_ channel. Events are handled one at a time:
// the slot table sits in single-port memories that are scanned one slot per cycle from slot
// 0 upward, stopping at the first free slot (allocation) or the first live slot with the same
// address (release); a null address is reported without a scan. The result waits in an output
// register, so a stalled m_ channel holds back only the commit of the following event.
module heap_allocation_tracker_core import hat_pkg::*; #(
    parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hat_datapath #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_payload (m_payload)
    );

endmodule

### rtl/core/hat_ctrl.sv
// controller state machine: accept, slot scan, commit and result handshake
module hat_ctrl import hat_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.is_null || stat.hit || stat.scan_end) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.issue = 1'b1;
                end
            end
            S_COMMIT: begin
                // wait until the result register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### rtl/core/hat_datapath.sv
// datapath: event registers, slot table, scan pipeline, counters and result register
module hat_datapath import hat_pkg::*; #(
    parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  in_t      s_payload,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output out_t     m_payload
);

    localparam int KEY_BITS = (ADDRESS_BITS < FIELD_ADDR_BITS) ? ADDRESS_BITS : FIELD_ADDR_BITS;
    localparam int IDX_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W    = $clog2(TABLE_SLOTS + 1);
    localparam int SLOT_EXT = (IDX_W > SLOT_FIELD_BITS) ? IDX_W : SLOT_FIELD_BITS;

    // event under work
    kind_t                kind_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [15:0]          size_reg;

    // slot table
    logic [TABLE_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [KEY_BITS-1:0]    addr_mem [TABLE_SLOTS];
    logic [15:0]            size_mem [TABLE_SLOTS];

    // scan pipeline
    logic [CNT_W-1:0]    idx_reg;
    logic                rd_live_reg;
    logic                rd_valid_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [15:0]         rd_size_reg;
    logic [IDX_W-1:0]    rd_idx_reg;

    // running totals
    logic [15:0] in_use_reg, in_use_next;
    logic [15:0] alloc_sum_reg, alloc_sum_next;
    logic [15:0] freed_sum_reg, freed_sum_next;
    logic [15:0] alloc_cnt_reg, alloc_cnt_next;
    logic [15:0] free_cnt_reg, free_cnt_next;

    out_t                out_reg, out_next;
    logic                match;
    logic                do_alloc;
    logic                do_free;
    logic [SLOT_EXT-1:0] slot_ext;

    assign match = (kind_reg == EV_ALLOC) ? !rd_valid_reg
                                          : (rd_valid_reg && (rd_key_reg == key_reg));

    assign stat.is_null  = (key_reg == '0);
    assign stat.hit      = rd_live_reg && match;
    assign stat.scan_end = (idx_reg == CNT_W'(TABLE_SLOTS));

    assign do_alloc = cmd.commit && !stat.is_null && stat.hit && (kind_reg == EV_ALLOC);
    assign do_free  = cmd.commit && !stat.is_null && stat.hit && (kind_reg == EV_RELEASE);
    assign slot_ext = SLOT_EXT'(rd_idx_reg);

    always_comb begin
        slot_valid_next = slot_valid_reg;
        in_use_next     = in_use_reg;
        alloc_sum_next  = alloc_sum_reg;
        freed_sum_next  = freed_sum_reg;
        alloc_cnt_next  = alloc_cnt_reg;
        free_cnt_next   = free_cnt_reg;
        if (do_alloc) begin
            slot_valid_next[rd_idx_reg] = 1'b1;
            in_use_next    = in_use_reg + size_reg;
            alloc_sum_next = alloc_sum_reg + size_reg;
            alloc_cnt_next = alloc_cnt_reg + 16'd1;
        end
        if (do_free) begin
            slot_valid_next[rd_idx_reg] = 1'b0;
            in_use_next    = in_use_reg - rd_size_reg;
            freed_sum_next = freed_sum_reg + rd_size_reg;
            free_cnt_next  = free_cnt_reg + 16'd1;
        end
    end

    always_comb begin
        out_next.slot            = '0;
        out_next.released_size   = '0;
        out_next.bytes_in_use    = in_use_next;
        out_next.total_allocated = alloc_sum_next;
        out_next.total_freed     = freed_sum_next;
        out_next.alloc_events    = alloc_cnt_next;
        out_next.free_events     = free_cnt_next;
        if (stat.is_null) begin
            out_next.status = ST_NULL;
        end else if (kind_reg == EV_ALLOC) begin
            out_next.status = stat.hit ? ST_ALLOC : ST_FULL;
        end else begin
            out_next.status = stat.hit ? ST_FREED : ST_UNTRACKED;
        end
        if (do_alloc || do_free) begin
            out_next.slot = slot_ext[SLOT_FIELD_BITS-1:0];
        end
        if (do_free) begin
            out_next.released_size = rd_size_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            idx_reg        <= '0;
            rd_live_reg    <= 1'b0;
            in_use_reg     <= '0;
            alloc_sum_reg  <= '0;
            freed_sum_reg  <= '0;
            alloc_cnt_reg  <= '0;
            free_cnt_reg   <= '0;
        end else begin
            slot_valid_reg <= slot_valid_next;
            in_use_reg     <= in_use_next;
            alloc_sum_reg  <= alloc_sum_next;
            freed_sum_reg  <= freed_sum_next;
            alloc_cnt_reg  <= alloc_cnt_next;
            free_cnt_reg   <= free_cnt_next;
            if (cmd.load) begin
                idx_reg     <= '0;
                rd_live_reg <= 1'b0;
            end else if (cmd.issue) begin
                idx_reg     <= idx_reg + CNT_W'(1);
                rd_live_reg <= 1'b1;
            end
        end
    end

    // payload registers and slot memories
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_payload.kind;
            key_reg  <= s_payload.address[KEY_BITS-1:0];
            size_reg <= s_payload.block_size;
        end
        if (cmd.issue) begin
            rd_valid_reg <= slot_valid_reg[idx_reg[IDX_W-1:0]];
            rd_key_reg   <= addr_mem[idx_reg[IDX_W-1:0]];
            rd_size_reg  <= size_mem[idx_reg[IDX_W-1:0]];
            rd_idx_reg   <= idx_reg[IDX_W-1:0];
        end
        if (do_alloc) begin
            addr_mem[rd_idx_reg] <= key_reg;
            size_mem[rd_idx_reg] <= size_reg;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign m_payload = out_reg;

endmodule

### rtl/core/hat_checker.sv
// port-level checker of the heap allocation tracker and its bind
module hat_checker import hat_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_payload
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // one event in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an event is in work");

    a_rel_size_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status != ST_FREED) |-> (m_payload.released_size == 16'd0))
        else $error("released size set on a result that frees nothing");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status == ST_FULL || m_payload.status == ST_UNTRACKED
                    || m_payload.status == ST_NULL) |-> (m_payload.slot == '0))
        else $error("slot set on a result that touches no slot");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind heap_allocation_tracker_core hat_checker u_checker (.*);
